// File: hdl/pew_pkg.sv
package pew_pkg;

   // field types
   typedef logic signed [23:0] q816_type;   // position, Q8.16 m
   typedef logic signed [15:0] q14_type;    // rotation, Q2.14
   typedef logic signed [15:0] q124_type;   // packed register component, Q12.4

   // datapath widths
   localparam int MASS_W       = 16;
   localparam int CSR_W        = 48;
   localparam int COMP_W       = 16;
   localparam int MG_W         = 33;   // unsigned Q8.8 mass times Q12.4 gravity
   localparam int PROD_W       = 32;   // Q2.14 times Q12.4
   localparam int FORCE_W      = 40;   // exact force, Q.18
   localparam int TROT_W       = 34;   // rotated local torque, Q.18
   localparam int SPLIT_W      = 20;   // low half of the force for the cross product
   localparam int PH_W         = 44;   // position times signed force high half
   localparam int PL_W         = 45;   // position times unsigned force low half
   localparam int TADD_W       = 51;   // local plus global torque, Q.34
   localparam int T_W          = 64;   // exact torque, Q.34
   localparam int OUT_W        = 32;
   localparam int MG_SHIFT     = 6;
   localparam int FG_SHIFT     = 14;
   localparam int TL_SHIFT     = 16;
   localparam int TG_SHIFT     = 30;
   localparam int FORCE_SHIFT  = 10;   // Q.18 -> Q.8
   localparam int TORQUE_SHIFT = 26;   // Q.34 -> Q.8

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_VEC   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_LOCAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_GLOBAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_LOCAL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_GLOBAL = 3'd5;

   localparam logic signed [T_W-1:0] RES_MAX = 64'sd2147483647;
   localparam logic signed [T_W-1:0] RES_MIN = -64'sd2147483648;

   typedef struct packed {
      q816_type pos_x;
      q816_type pos_y;
      q816_type pos_z;
      q14_type  rot_00;
      q14_type  rot_01;
      q14_type  rot_02;
      q14_type  rot_10;
      q14_type  rot_11;
      q14_type  rot_12;
      q14_type  rot_20;
      q14_type  rot_21;
      q14_type  rot_22;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] force_x;
      logic signed [OUT_W-1:0] force_y;
      logic signed [OUT_W-1:0] force_z;
      logic signed [OUT_W-1:0] torque_x;
      logic signed [OUT_W-1:0] torque_y;
      logic signed [OUT_W-1:0] torque_z;
      logic                    saturated;
   } rsp_word_type;

   // per-axis result of one lane
   typedef struct packed {
      logic signed [FORCE_W-1:0] frc;
      logic signed [TROT_W-1:0]  trot;
   } lane_out_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    sat;
   } sat_result_type;

   // round half up by n bits, then clip to 32 bits
   function automatic sat_result_type round_sat(input logic signed [T_W-1:0] v,
                                                input int unsigned n);
      logic signed [T_W-1:0] r;
      sat_result_type res;
      r = (v + (64'sd1 <<< (n - 1))) >>> n;
      if (r > RES_MAX) begin
         res.value = RES_MAX[OUT_W-1:0];
         res.sat   = 1'b1;
      end else if (r < RES_MIN) begin
         res.value = RES_MIN[OUT_W-1:0];
         res.sat   = 1'b1;
      end else begin
         res.value = r[OUT_W-1:0];
         res.sat   = 1'b0;
      end
      return res;
   endfunction

endpackage

// File: hdl/pew_lane.sv
// One axis: row i of the force sum and of R*t_loc. Two register stages.
module pew_lane (
   input  logic                 clock,
   input  logic                 en,
   input  logic [15:0]          mass,
   input  pew_pkg::q14_type     rot [3],
   input  pew_pkg::q124_type    grav,
   input  pew_pkg::q124_type    fl_vec [3],
   input  pew_pkg::q124_type    fg,
   input  pew_pkg::q124_type    tl_vec [3],
   output pew_pkg::lane_out_type lane_out
);
   import pew_pkg::*;

   logic signed [MG_W-1:0]   mg_ff, mg_in;
   logic signed [PROD_W-1:0] rf_ff [3];
   logic signed [PROD_W-1:0] rf_in [3];
   logic signed [PROD_W-1:0] rt_ff [3];
   logic signed [PROD_W-1:0] rt_in [3];
   q124_type                 fg_ff;
   lane_out_type             out_ff, out_in;

   always_comb begin
      mg_in = $signed({1'b0, mass}) * $signed(grav);
      for (int k = 0; k < 3; k++) begin
         rf_in[k] = $signed(rot[k]) * $signed(fl_vec[k]);
         rt_in[k] = $signed(rot[k]) * $signed(tl_vec[k]);
      end
   end

   // stage 2: sum in Q.18
   always_comb begin
      out_in.frc  = (FORCE_W'(mg_ff) <<< MG_SHIFT)
                  + FORCE_W'(rf_ff[0]) + FORCE_W'(rf_ff[1]) + FORCE_W'(rf_ff[2])
                  + (FORCE_W'(fg_ff) <<< FG_SHIFT);
      out_in.trot = TROT_W'(rt_ff[0]) + TROT_W'(rt_ff[1]) + TROT_W'(rt_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mg_ff  <= mg_in;
         rf_ff  <= rf_in;
         rt_ff  <= rt_in;
         fg_ff  <= fg;
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

// File: hdl/pew_merge.sv
// Cross product p x F over the three lanes, torque sum, rounding and clipping.
// Two register stages; the rounded word leaves combinationally.
module pew_merge (
   input  logic                  clock,
   input  logic                  en,
   input  pew_pkg::lane_out_type lanes [3],
   input  pew_pkg::q816_type     pos [3],
   input  pew_pkg::q124_type     tg [3],
   output pew_pkg::rsp_word_type word
);
   import pew_pkg::*;

   // stage 3: split partial products, torque sum and rounded force
   logic signed [PH_W-1:0]   ph_a_ff [3];
   logic signed [PH_W-1:0]   ph_a_in [3];
   logic signed [PL_W-1:0]   pl_a_ff [3];
   logic signed [PL_W-1:0]   pl_a_in [3];
   logic signed [PH_W-1:0]   ph_b_ff [3];
   logic signed [PH_W-1:0]   ph_b_in [3];
   logic signed [PL_W-1:0]   pl_b_ff [3];
   logic signed [PL_W-1:0]   pl_b_in [3];
   logic signed [TADD_W-1:0] tadd_ff [3];
   logic signed [TADD_W-1:0] tadd_in [3];
   sat_result_type           fq_ff [3];
   sat_result_type           fq_in [3];
   // stage 4: exact torque and delayed rounded force
   logic signed [T_W-1:0]    t_ff [3];
   logic signed [T_W-1:0]    t_in [3];
   sat_result_type           fq2_ff [3];
   sat_result_type           tq [3];

   for (genvar i = 0; i < 3; i++) begin : g_axis
      localparam int A = (i + 1) % 3;
      localparam int B = (i + 2) % 3;

      // t_i = p_a * f_b - p_b * f_a, force split as signed high / unsigned low
      always_comb begin
         ph_a_in[i] = $signed(pos[A])
                    * $signed(lanes[B].frc[FORCE_W-1:SPLIT_W]);
         pl_a_in[i] = $signed(pos[A])
                    * $signed({1'b0, lanes[B].frc[SPLIT_W-1:0]});
         ph_b_in[i] = $signed(pos[B])
                    * $signed(lanes[A].frc[FORCE_W-1:SPLIT_W]);
         pl_b_in[i] = $signed(pos[B])
                    * $signed({1'b0, lanes[A].frc[SPLIT_W-1:0]});
         tadd_in[i] = (TADD_W'(lanes[i].trot) <<< TL_SHIFT)
                    + (TADD_W'(tg[i]) <<< TG_SHIFT);
         fq_in[i]   = round_sat(T_W'(lanes[i].frc), FORCE_SHIFT);
      end

      always_comb begin
         t_in[i] = (T_W'(ph_a_ff[i]) <<< SPLIT_W) + T_W'(pl_a_ff[i])
                 - (T_W'(ph_b_ff[i]) <<< SPLIT_W) - T_W'(pl_b_ff[i])
                 + T_W'(tadd_ff[i]);
         tq[i]   = round_sat(t_ff[i], TORQUE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_a_ff <= ph_a_in;
         pl_a_ff <= pl_a_in;
         ph_b_ff <= ph_b_in;
         pl_b_ff <= pl_b_in;
         tadd_ff <= tadd_in;
         fq_ff   <= fq_in;
         t_ff    <= t_in;
         fq2_ff  <= fq_ff;
      end
   end

   always_comb begin
      word.force_x   = fq2_ff[0].value;
      word.force_y   = fq2_ff[1].value;
      word.force_z   = fq2_ff[2].value;
      word.torque_x  = tq[0].value;
      word.torque_y  = tq[1].value;
      word.torque_z  = tq[2].value;
      word.saturated = fq2_ff[0].sat | fq2_ff[1].sat | fq2_ff[2].sat
                     | tq[0].sat | tq[1].sat | tq[2].sat;
   end

endmodule

// File: hdl/platform_external_wrench_unit.sv
// Channel   Direction  Handshake               Word
// req       in         req_valid / req_stall   req_word (pose: position, rotation)
// rsp       out        rsp_valid / rsp_stall   rsp_word (force, torque, saturated)
// csr       in         csr_we                  csr_index, csr_data (48 bits)
//
// One pose per clock while req_stall is low. An accepted word reaches rsp
// through two lane stages, two merge stages and the output register.
// Reset (synchronous) empties the pipe and clears the valid flags and configuration registers to zero.
// A pipe word that meets a stalled output word parks in a one-word skid register; while it is full,
// req_stall is high and the whole pipe holds.
module platform_external_wrench_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pew_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pew_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_we,
   input  logic [pew_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pew_pkg::CSR_W-1:0]         csr_data
);
   import pew_pkg::*;

   // configuration
   logic [MASS_W-1:0] mass_ff;
   logic [CSR_W-1:0]  gravity_ff;
   logic [CSR_W-1:0]  force_local_ff;
   logic [CSR_W-1:0]  force_global_ff;
   logic [CSR_W-1:0]  torque_local_ff;
   logic [CSR_W-1:0]  torque_global_ff;

   // register components: x bits 15:0, y 31:16, z 47:32
   q124_type g_c [3];
   q124_type fl_c [3];
   q124_type fg_c [3];
   q124_type tl_c [3];
   q124_type tg_c [3];

   q14_type      rot_m [3][3];
   q816_type     pos_in [3];
   q816_type     pos_s1_ff [3];
   q816_type     pos_s2_ff [3];
   lane_out_type lane_res [3];
   rsp_word_type pipe_word;

   // valid of stages 1..4; bit 3 means pipe_word is live
   logic [3:0]   vpipe_ff;
   logic         en;
   logic         out_free;
   logic         push;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   logic         skid_valid_ff;
   rsp_word_type skid_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff          <= '0;
         gravity_ff       <= '0;
         force_local_ff   <= '0;
         force_global_ff  <= '0;
         torque_local_ff  <= '0;
         torque_global_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MASS:          mass_ff          <= csr_data[MASS_W-1:0];
            CSR_GRAVITY_VEC:   gravity_ff       <= csr_data;
            CSR_FORCE_LOCAL:   force_local_ff   <= csr_data;
            CSR_FORCE_GLOBAL:  force_global_ff  <= csr_data;
            CSR_TORQUE_LOCAL:  torque_local_ff  <= csr_data;
            CSR_TORQUE_GLOBAL: torque_global_ff <= csr_data;
            default: ;   // unmapped index: dropped
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         g_c[k]  = gravity_ff[COMP_W*k +: COMP_W];
         fl_c[k] = force_local_ff[COMP_W*k +: COMP_W];
         fg_c[k] = force_global_ff[COMP_W*k +: COMP_W];
         tl_c[k] = torque_local_ff[COMP_W*k +: COMP_W];
         tg_c[k] = torque_global_ff[COMP_W*k +: COMP_W];
      end
      rot_m[0][0] = req_word.rot_00;
      rot_m[0][1] = req_word.rot_01;
      rot_m[0][2] = req_word.rot_02;
      rot_m[1][0] = req_word.rot_10;
      rot_m[1][1] = req_word.rot_11;
      rot_m[1][2] = req_word.rot_12;
      rot_m[2][0] = req_word.rot_20;
      rot_m[2][1] = req_word.rot_21;
      rot_m[2][2] = req_word.rot_22;
      pos_in[0]   = req_word.pos_x;
      pos_in[1]   = req_word.pos_y;
      pos_in[2]   = req_word.pos_z;
   end

   // pipe moves as a whole unless the skid register is occupied
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push      = vpipe_ff[3] && en;

   // one lane per axis
   for (genvar i = 0; i < 3; i++) begin : g_lane
      pew_lane u_lane (
         .clock    (clock),
         .en       (en),
         .mass     (mass_ff),
         .rot      (rot_m[i]),
         .grav     (g_c[i]),
         .fl_vec   (fl_c),
         .fg       (fg_c[i]),
         .tl_vec   (tl_c),
         .lane_out (lane_res[i])
      );
   end

   // position rides alongside the lane stages
   always_ff @(posedge clock) begin
      if (en) begin
         pos_s1_ff <= pos_in;
         pos_s2_ff <= pos_s1_ff;
      end
   end

   pew_merge u_merge (
      .clock (clock),
      .en    (en),
      .lanes (lane_res),
      .pos   (pos_s2_ff),
      .tg    (tg_c),
      .word  (pipe_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vpipe_ff <= '0;
      end else if (en) begin
         vpipe_ff <= {vpipe_ff[2:0], req_valid};
      end
   end

   // output register plus skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_word_ff <= skid_word_ff;
         end else begin
            rsp_word_ff <= pipe_word;
         end
      end else if (push) begin
         skid_word_ff <= pipe_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // skid only ever holds a word behind a live output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without output word");

   // skid fills only when the output word was stalled
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall && vpipe_ff[3]))
      else $error("skid filled without a stalled output");

   // a full skid freezes the pipe
   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(vpipe_ff))
      else $error("pipe moved while skid full");

   // a taken output drains the skid into the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff && rsp_valid_ff)
      else $error("skid did not drain");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Testbench for platform_external_wrench_unit.
// Driver and monitor are clocked always blocks; the initial block below
// sets the registers, fills the pose queue phase by phase and waits for
// the pipe to empty before the next register setting.
module tb;
   import pew_pkg::*;

   // indexes past the register map; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   // handy field values
   localparam logic [23:0] POS_MAX  = 24'h7FFFFF;
   localparam logic [23:0] POS_MIN  = 24'h800000;
   localparam logic [23:0] POS_ONE  = 24'h010000;   // 1 m in Q8.16
   localparam logic [15:0] ROT_ONE  = 16'h4000;     // 1.0 in Q2.14
   localparam logic [15:0] ROT_NEG  = 16'hC000;     // -1.0
   localparam logic [15:0] ROT_MAX  = 16'h7FFF;
   localparam logic [15:0] ROT_MIN  = 16'h8000;
   localparam logic [15:0] ROT_HALF = 16'h0200;     // times 1/16 gives half an output LSB
   localparam logic [15:0] C_MAX    = 16'h7FFF;
   localparam logic [15:0] C_MIN    = 16'h8000;
   localparam logic [143:0] ROT_IDENT = {ROT_ONE, 16'h0, 16'h0,
                                         16'h0, ROT_ONE, 16'h0,
                                         16'h0, 16'h0, ROT_ONE};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data  = '0;

   // shadow of the register file, as the predictor sees it
   logic [MASS_W-1:0] cfg_mass       = '0;
   logic [CSR_W-1:0]  cfg_gravity    = '0;
   logic [CSR_W-1:0]  cfg_force_loc  = '0;
   logic [CSR_W-1:0]  cfg_force_glb  = '0;
   logic [CSR_W-1:0]  cfg_torque_loc = '0;
   logic [CSR_W-1:0]  cfg_torque_glb = '0;

   req_word_type pending_poses[$];
   rsp_word_type expected_wrench[$];
   int           mismatch_count = 0;
   int           src_gap  = 0;
   int           sink_gap = 0;
   bit           idle_enable = 1'b1;

   platform_external_wrench_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Wrench predictor
   // ---------------------------------------------------------------

   // one signed Q12.4 component of a packed register (x = 0, y = 1, z = 2)
   function automatic longint reg_comp(input logic [CSR_W-1:0] r, input int k);
      logic signed [COMP_W-1:0] c;
      c = r[k*COMP_W +: COMP_W];
      return c;
   endfunction

   // round half toward +inf by sh bits, clip to 32 bits, flag clipping
   function automatic logic signed [OUT_W-1:0] round_clip_q8(input longint v, input int sh,
                                                             inout logic sat);
      longint r;
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r > 64'sd2147483647) begin
         sat = 1'b1;
         r = 64'sd2147483647;
      end else if (r < -64'sd2147483648) begin
         sat = 1'b1;
         r = -64'sd2147483648;
      end
      return r[OUT_W-1:0];
   endfunction

   function automatic rsp_word_type predict_wrench(input req_word_type w);
      longint p[3];
      longint rot[9];
      longint frc[3];
      longint trq[3];
      longint acc;
      longint m;
      logic   sat;
      rsp_word_type o;
      p[0] = $signed(w.pos_x);
      p[1] = $signed(w.pos_y);
      p[2] = $signed(w.pos_z);
      rot[0] = $signed(w.rot_00);
      rot[1] = $signed(w.rot_01);
      rot[2] = $signed(w.rot_02);
      rot[3] = $signed(w.rot_10);
      rot[4] = $signed(w.rot_11);
      rot[5] = $signed(w.rot_12);
      rot[6] = $signed(w.rot_20);
      rot[7] = $signed(w.rot_21);
      rot[8] = $signed(w.rot_22);
      m = cfg_mass;
      sat = 1'b0;
      // force, exact in Q.18
      for (int i = 0; i < 3; i++) begin
         acc = m * reg_comp(cfg_gravity, i) * 64;
         for (int j = 0; j < 3; j++)
            acc += rot[3*i+j] * reg_comp(cfg_force_loc, j);
         acc += reg_comp(cfg_force_glb, i) * 16384;
         frc[i] = acc;
      end
      // torque, exact in Q.34; cross product uses the unrounded force
      trq[0] = p[1] * frc[2] - p[2] * frc[1];
      trq[1] = p[2] * frc[0] - p[0] * frc[2];
      trq[2] = p[0] * frc[1] - p[1] * frc[0];
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++)
            acc += rot[3*i+j] * reg_comp(cfg_torque_loc, j);
         trq[i] += acc * 65536;
         trq[i] += reg_comp(cfg_torque_glb, i) * 64'sd1073741824;
      end
      o.force_x   = round_clip_q8(frc[0], FORCE_SHIFT, sat);
      o.force_y   = round_clip_q8(frc[1], FORCE_SHIFT, sat);
      o.force_z   = round_clip_q8(frc[2], FORCE_SHIFT, sat);
      o.torque_x  = round_clip_q8(trq[0], TORQUE_SHIFT, sat);
      o.torque_y  = round_clip_q8(trq[1], TORQUE_SHIFT, sat);
      o.torque_z  = round_clip_q8(trq[2], TORQUE_SHIFT, sat);
      o.saturated = sat;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Driver: req side. Expectation is formed at the accepting edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_wrench.push_back(predict_wrench(req_word));
         // a stalled word stays put
         if (!(req_valid && req_stall)) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (pending_poses.size() > 0) begin
               req_valid <= 1'b1;
               req_word  <= pending_poses.pop_front();
               if (idle_enable && $urandom_range(0, 4) == 0)
                  src_gap = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: rsp side, random stall bursts, in-order compare
   // ---------------------------------------------------------------
   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_wrench.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: word with nothing expected", $time);
            end else begin
               want = expected_wrench.pop_front();
               compare_field("force_x", want.force_x, rsp_word.force_x);
               compare_field("force_y", want.force_y, rsp_word.force_y);
               compare_field("force_z", want.force_z, rsp_word.force_z);
               compare_field("torque_x", want.torque_x, rsp_word.torque_x);
               compare_field("torque_y", want.torque_y, rsp_word.torque_y);
               compare_field("torque_z", want.torque_z, rsp_word.torque_z);
               compare_field("saturated", want.saturated, rsp_word.saturated);
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_enable && $urandom_range(0, 4) == 0)
               sink_gap = $urandom_range(1, 7);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // one register write; the shadow follows after the write edge
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MASS:          cfg_mass       = val[MASS_W-1:0];
         CSR_GRAVITY_VEC:   cfg_gravity    = val;
         CSR_FORCE_LOCAL:   cfg_force_loc  = val;
         CSR_FORCE_GLOBAL:  cfg_force_glb  = val;
         CSR_TORQUE_LOCAL:  cfg_torque_loc = val;
         CSR_TORQUE_GLOBAL: cfg_torque_glb = val;
         default: ;
      endcase
   endtask

   // full register set; mass goes with junk above bit 15, spare indexes get noise
   task automatic set_config(input logic [15:0] m, input logic [47:0] g, fl, fg, tl, tg);
      write_csr(CSR_MASS, {16'($urandom), 16'($urandom), m});
      write_csr(CSR_GRAVITY_VEC, g);
      write_csr(CSR_FORCE_LOCAL, fl);
      write_csr(CSR_FORCE_GLOBAL, fg);
      write_csr(CSR_TORQUE_LOCAL, tl);
      write_csr(CSR_TORQUE_GLOBAL, tg);
      write_csr(CSR_SPARE_6, {16'($urandom), 32'($urandom)});
      write_csr(CSR_SPARE_7, {16'($urandom), 32'($urandom)});
      @(negedge clock);
   endtask

   // wait for the pipe to drain, then cover the block latency
   task automatic wait_idle();
      @(negedge clock);
      while (pending_poses.size() != 0 || req_valid || expected_wrench.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic queue_pose(input logic [23:0] px, py, pz, input logic [143:0] rot);
      pending_poses.push_back({px, py, pz, rot});
   endtask

   // saturating corners, used under both extreme register sets
   task automatic queue_corner_poses();
      queue_pose(POS_MAX, POS_MAX, POS_MAX, {9{ROT_MAX}});
      queue_pose(POS_MIN, POS_MIN, POS_MIN, {9{ROT_MIN}});
      queue_pose(POS_MAX, POS_MIN, POS_MAX, {9{ROT_MAX}});
      queue_pose(POS_MIN, POS_MAX, POS_MIN, {ROT_MIN, ROT_MAX, ROT_MIN, ROT_MAX, ROT_MIN,
                                             ROT_MAX, ROT_MIN, ROT_MAX, ROT_MIN});
      queue_pose(24'h0, 24'h0, 24'h0, ROT_IDENT);
   endtask

   function automatic logic [15:0] rand_comp();
      logic signed [9:0] s;
      s = 10'($urandom);
      case ($urandom_range(0, 9))
         0: return C_MAX;
         1: return C_MIN;
         2: return 16'h0;
         3, 4, 5: return {{6{s[9]}}, s};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_mass();
      case ($urandom_range(0, 7))
         0: return 16'hFFFF;
         1: return 16'h0;
         2, 3, 4: return 16'($urandom_range(64, 4096));   // a few kg
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_pos(input bit plausible);
      logic signed [19:0] s;
      s = 20'($urandom);
      if (plausible)
         return {{4{s[19]}}, s};
      case ($urandom_range(0, 7))
         0: return POS_MAX;
         1: return POS_MIN;
         2: return 24'h0;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_rot(input bit plausible);
      logic signed [14:0] s;
      s = 15'($urandom);
      if (plausible)
         return {s[14], s};
      case ($urandom_range(0, 7))
         0: return ROT_MAX;
         1: return ROT_MIN;
         2: return 16'h0;
         3: return ROT_ONE;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly poses of realistic size, the rest anything the fields allow
   function automatic req_word_type rand_pose();
      req_word_type w;
      bit           ok;
      ok = ($urandom_range(0, 9) < 6);
      w.pos_x  = rand_pos(ok);
      w.pos_y  = rand_pos(ok);
      w.pos_z  = rand_pos(ok);
      w.rot_00 = rand_rot(ok);
      w.rot_01 = rand_rot(ok);
      w.rot_02 = rand_rot(ok);
      w.rot_10 = rand_rot(ok);
      w.rot_11 = rand_rot(ok);
      w.rot_12 = rand_rot(ok);
      w.rot_20 = rand_rot(ok);
      w.rot_21 = rand_rot(ok);
      w.rot_22 = rand_rot(ok);
      return w;
   endfunction

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: everything must come out zero
      @(negedge clock);
      queue_pose(POS_MAX, POS_MAX, POS_MAX, {9{ROT_MAX}});
      queue_pose(POS_MIN, POS_MIN, POS_MIN, {9{ROT_MIN}});
      wait_idle();

      // rounding ties: force and torque land exactly on +-0.5 and +-1.5 LSB
      set_config(16'h0, 48'h0, {16'h0, 16'h0, 16'h0001}, 48'h0,
                 {16'h0, 16'h0, 16'h0001}, 48'h0);
      queue_pose(24'h0, 24'h0, 24'h0, {ROT_HALF, 32'h0, ROT_HALF, 32'h0, ROT_HALF, 32'h0});
      queue_pose(24'h0, 24'h0, 24'h0, {-ROT_HALF, 32'h0, -ROT_HALF, 32'h0,
                                       -ROT_HALF, 32'h0});
      queue_pose(24'h0, 24'h0, 24'h0, {16'(3 * ROT_HALF), 32'h0, 16'(3 * ROT_HALF), 32'h0,
                                       16'(3 * ROT_HALF), 32'h0});
      queue_pose(24'h0, 24'h0, 24'h0, {16'(-(3 * ROT_HALF)), 32'h0,
                                       16'(-(3 * ROT_HALF)), 32'h0,
                                       16'(-(3 * ROT_HALF)), 32'h0});
      wait_idle();

      // nominal: 1 kg under -9.8 g on z, small local and global loads
      set_config(16'h0100, {16'hFF63, 16'h0, 16'h0}, {16'h0, 16'h0, 16'h0010},
                 {16'h0, 16'h0020, 16'h0}, {16'h0008, 16'h0, 16'h0},
                 {16'h0, 16'h0, 16'h0004});
      queue_pose(24'h0, 24'h0, 24'h0, ROT_IDENT);
      queue_pose(POS_ONE, 24'h0, 24'h0, ROT_IDENT);
      // quarter turn about z, offset lever arm
      queue_pose(24'h0, POS_ONE, 24'h008000, {16'h0, ROT_NEG, 16'h0, ROT_ONE, 16'h0,
                                              16'h0, 16'h0, 16'h0, ROT_ONE});
      // not orthonormal at all
      queue_pose(POS_ONE, POS_ONE, POS_ONE, {9{ROT_MAX}});
      queue_pose(POS_MAX, POS_MAX, POS_MAX, ROT_IDENT);
      queue_pose(POS_MIN, POS_MIN, POS_MIN, ROT_IDENT);
      queue_pose(POS_MAX, POS_MIN, 24'h0, {ROT_MAX, ROT_MIN, 16'h0, ROT_MIN, ROT_MAX,
                                           16'h0, 16'h0, 16'h0, ROT_MAX});
      wait_idle();

      // extreme registers, both polarities, with saturating poses
      set_config(16'hFFFF, {3{C_MIN}}, {3{C_MAX}}, {3{C_MIN}}, {3{C_MAX}}, {3{C_MAX}});
      queue_corner_poses();
      wait_idle();
      set_config(16'hFFFF, {3{C_MAX}}, {3{C_MIN}}, {3{C_MAX}}, {3{C_MIN}}, {3{C_MIN}});
      queue_corner_poses();
      wait_idle();

      // random register sets, random poses; some phases run without idling,
      // the last one included
      for (int ph = 0; ph < 8; ph++) begin
         set_config(rand_mass(), {rand_comp(), rand_comp(), rand_comp()},
                    {rand_comp(), rand_comp(), rand_comp()},
                    {rand_comp(), rand_comp(), rand_comp()},
                    {rand_comp(), rand_comp(), rand_comp()},
                    {rand_comp(), rand_comp(), rand_comp()});
         idle_enable = (ph != 3 && ph != 7);
         repeat (60) pending_poses.push_back(rand_pose());
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_wrench.size() == 0)
         $display("platform_external_wrench_unit: match");
      else
         $display("platform_external_wrench_unit: mismatch");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("platform_external_wrench_unit: mismatch");
      $finish;
   end

endmodule
